// File: hw/rtl/twctl_pkg.sv
// Package for the two-way cache tag lookup: widths, opcodes, status codes and shared types.
`timescale 1ns / 1ps

package twctl_pkg;

  // Instruction word layout
  localparam int INSTR_W    = 32;
  localparam int OPCODE_W   = 6;
  localparam int RS_W       = 5;
  localparam int OFFSET_W   = 16;
  localparam int OPCODE_LSB = 26;
  localparam int RS_LSB     = 21;

  localparam logic [OPCODE_W-1:0] OP_LOAD  = 6'd35;
  localparam logic [OPCODE_W-1:0] OP_STORE = 6'd43;

  // Address arithmetic: offset plus rs needs one extra bit, word address drops two
  localparam int BYTE_ADDR_W  = OFFSET_W + 1;
  localparam int BYTE_SHIFT   = 2;
  localparam int WADDR_W      = BYTE_ADDR_W - BYTE_SHIFT;

  // Cache geometry; the set count is a power of two
  localparam int SET_W     = 3;
  localparam int NUM_SETS  = 1 << SET_W;
  localparam int NUM_WAYS  = 2;
  localparam int WAY_W     = 1;
  localparam int TAG_W     = 12;
  localparam int ROW_W     = NUM_WAYS * TAG_W;

  // Result field widths
  localparam int STATUS_W  = 2;
  localparam int SET_OUT_W = 3;

  typedef enum logic [STATUS_W-1:0] {
    ST_HIT   = 2'd0,
    ST_MISS  = 2'd1,
    ST_NOMEM = 2'd2
  } status_t;

  typedef logic [NUM_WAYS-1:0][TAG_W-1:0] tag_row_t;

  // Decoded memory access
  typedef struct packed {
    logic               is_mem;
    logic [SET_W-1:0]   set;
    logic [TAG_W-1:0]   tag;
    logic [WADDR_W-1:0] waddr;
  } dec_t;

  // Way selection outcome
  typedef struct packed {
    logic             hit;
    logic [WAY_W-1:0] way;
  } sel_t;

endpackage

// File: hw/rtl/twctl_if.sv
// Valid/ready channel interfaces for instruction words and lookup results.
`timescale 1ns / 1ps

interface twctl_in_if import twctl_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [INSTR_W-1:0] instruction_word;

  modport source (output valid, output instruction_word, input ready);
  modport sink (input valid, input instruction_word, output ready);
endinterface

interface twctl_out_if import twctl_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [STATUS_W-1:0]  access_status;
  logic [SET_OUT_W-1:0] set_number;
  logic [TAG_W-1:0]     tag_value;
  logic [WAY_W-1:0]     way_used;
  logic [WADDR_W-1:0]   word_address;

  modport source (output valid, output access_status, output set_number, output tag_value,
                  output way_used, output word_address, input ready);
  modport sink (input valid, input access_status, input set_number, input tag_value,
                input way_used, input word_address, output ready);
endinterface

// File: hw/rtl/twctl_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps

module twctl_ram #(
  parameter int DEPTH = 8,
  parameter int WIDTH = 24
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, old data on a same-address collision
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hw/rtl/twctl_decode.sv
// Instruction decode: load/store detection and set/tag/word address split.
`timescale 1ns / 1ps

module twctl_decode import twctl_pkg::*; (
  input  logic [INSTR_W-1:0] instruction_word,
  output dec_t               dec
);

  logic [OPCODE_W-1:0]    opcode;
  logic [RS_W-1:0]        rs;
  logic [OFFSET_W-1:0]    offset;
  logic [BYTE_ADDR_W-1:0] byte_addr;
  logic [WADDR_W-1:0]     waddr;
  logic [WADDR_W-1:0]     tag_full;

  // Split the instruction word
  assign opcode = instruction_word[OPCODE_LSB +: OPCODE_W];
  assign rs     = instruction_word[RS_LSB +: RS_W];
  assign offset = instruction_word[OFFSET_W-1:0];

  // Form byte and word address
  assign byte_addr = BYTE_ADDR_W'(offset) + BYTE_ADDR_W'(rs);
  assign waddr     = byte_addr[BYTE_ADDR_W-1:BYTE_SHIFT];
  assign tag_full  = waddr >> SET_W;

  // Detect memory ops
  always_comb begin
    unique case (opcode) inside
      OP_LOAD, OP_STORE: dec.is_mem = 1'b1;
      default:           dec.is_mem = 1'b0;
    endcase
  end

  assign dec.set   = waddr[SET_W-1:0];
  assign dec.tag   = tag_full[TAG_W-1:0];
  assign dec.waddr = waddr;

endmodule

// File: hw/rtl/twctl_way_sel.sv
// Two-way tag compare, victim choice and updated tag row.
`timescale 1ns / 1ps

module twctl_way_sel import twctl_pkg::*; (
  input  logic [TAG_W-1:0]    tag,
  input  tag_row_t            row,
  input  logic [NUM_WAYS-1:0] valid,
  output sel_t                sel,
  output tag_row_t            row_next
);

  logic hit0;
  logic hit1;

  // Compare both ways
  assign hit0 = valid[0] && (row[0] == tag);
  assign hit1 = valid[1] && (row[1] == tag);

  // Pick hit way, else first invalid way, else way 1
  always_comb begin
    sel.hit = hit0 || hit1;
    if (hit0) begin
      sel.way = 1'b0;
    end else if (hit1) begin
      sel.way = 1'b1;
    end else begin
      sel.way = valid[0];
    end
  end

  // Replace the chosen way's tag
  always_comb begin
    row_next          = row;
    row_next[sel.way] = tag;
  end

endmodule

// File: hw/rtl/two_way_cache_tag_lookup.sv
// Top level of the two-way set-associative cache tag lookup.
`timescale 1ns / 1ps

// Takes one load/store instruction word per transfer and returns one result per word:
// hit, miss or not-a-memory-op, with set, tag, way and word address. Sustained rate is one
// item per cycle while result.ready stays high. The tag RAM is read as an instruction
// transfers in; compare and write-back happen as stage 1 drains, which also loads the output
// register. The tag store is a single RAM row per set holding both ways. A row is read at
// the input transfer and written back as its item moves to the output register. A
// back-to-back access to the same set takes the freshly written row from a forwarding
// register. Valid bits sit in flip-flops cleared by reset, so no clearing pass is needed.
// Non-memory ops report zero fields and leave the store untouched.
module two_way_cache_tag_lookup import twctl_pkg::*; (
  input logic        clk,
  input logic        rst,
  twctl_in_if.sink   instr,
  twctl_out_if.source result
);

  dec_t                                dec;
  dec_t                                s1_dec;
  logic                                s1_valid;
  logic                                s1_fire;
  logic                                in_acc;
  logic                                out_valid;
  logic                                fwd;
  tag_row_t                            fwd_row;
  logic [ROW_W-1:0]                    ram_rdata;
  tag_row_t                            row_eff;
  tag_row_t                            row_next;
  sel_t                                sel;
  logic                                we;
  logic [NUM_SETS-1:0][NUM_WAYS-1:0]   valid_q;
  status_t                             out_status;
  logic [SET_OUT_W-1:0]                out_set;
  logic [TAG_W-1:0]                    out_tag;
  logic [WAY_W-1:0]                    out_way;
  logic [WADDR_W-1:0]                  out_waddr;

  // Decode the incoming word
  twctl_decode u_decode (
    .instruction_word (instr.instruction_word),
    .dec              (dec)
  );

  // Handshake: stage 1 drains into the output register when it is free or being taken
  assign s1_fire     = s1_valid && (!out_valid || result.ready);
  assign instr.ready = !s1_valid || s1_fire;
  assign in_acc      = instr.valid && instr.ready;
  assign we          = s1_fire && s1_dec.is_mem;

  // Tag store, one row of both ways per set
  twctl_ram #(
    .DEPTH (NUM_SETS),
    .WIDTH (ROW_W)
  ) u_tag_ram (
    .clk   (clk),
    .we    (we),
    .waddr (s1_dec.set),
    .wdata (ROW_W'(row_next)),
    .re    (in_acc && dec.is_mem),
    .raddr (dec.set),
    .rdata (ram_rdata)
  );

  // Take the forwarded row when the previous item wrote this set during our read
  assign row_eff = fwd ? fwd_row : tag_row_t'(ram_rdata);

  twctl_way_sel u_way_sel (
    .tag      (s1_dec.tag),
    .row      (row_eff),
    .valid    (valid_q[s1_dec.set]),
    .sel      (sel),
    .row_next (row_next)
  );

  // Stage 1 control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_acc) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  // Stage 1 payload and forwarding capture
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_dec  <= dec;
      fwd     <= we && (s1_dec.set == dec.set);
      fwd_row <= row_next;
    end
  end

  // Valid bits: mark the way that hit or was filled
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= '0;
    end else if (we) begin
      valid_q[s1_dec.set][sel.way] <= 1'b1;
    end
  end

  // Output register control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (s1_fire) begin
      if (s1_dec.is_mem) begin
        out_status <= sel.hit ? ST_HIT : ST_MISS;
        out_set    <= SET_OUT_W'(s1_dec.set);
        out_tag    <= s1_dec.tag;
        out_way    <= sel.way;
        out_waddr  <= s1_dec.waddr;
      end else begin
        out_status <= ST_NOMEM;
        out_set    <= '0;
        out_tag    <= '0;
        out_way    <= '0;
        out_waddr  <= '0;
      end
    end
  end

  assign result.valid         = out_valid;
  assign result.access_status = out_status;
  assign result.set_number    = out_set;
  assign result.tag_value     = out_tag;
  assign result.way_used      = out_way;
  assign result.word_address  = out_waddr;

  // A stalled result with a full stage 1 blocks new transfers
  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    s1_valid && out_valid && !result.ready |-> !instr.ready)
    else $error("instruction accepted while pipeline is full");

  // The way written back is valid afterwards
  a_fill_valid: assert property (@(posedge clk) disable iff (rst)
    we |=> valid_q[$past(s1_dec.set)][$past(sel.way)])
    else $error("written way not marked valid");

  // A hit reported on a memory op always names a valid way
  a_hit_valid: assert property (@(posedge clk) disable iff (rst)
    s1_fire && s1_dec.is_mem && sel.hit |-> valid_q[s1_dec.set][sel.way])
    else $error("hit on an invalid way");

  // Non-memory results carry zero fields; the check covers word address and way
  a_nomem_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_status == ST_NOMEM) |-> (out_waddr == '0) && (out_way == '0))
    else $error("non-memory result carries address fields");

endmodule

// File: test/tb_two_way_cache_tag_lookup.sv
// Testbench for the two-way cache tag lookup: directed and random instruction streams.
`timescale 1ns / 1ps

module tb_two_way_cache_tag_lookup;
  import twctl_pkg::*;

  // One lookup outcome as it leaves the result channel
  typedef struct packed {
    status_t              status;
    logic [SET_OUT_W-1:0] set_num;
    logic [TAG_W-1:0]     tag;
    logic [WAY_W-1:0]     way;
    logic [WADDR_W-1:0]   waddr;
  } lookup_result_t;

  localparam int MAX_BYTE_ADDR = 65535 + 31;
  localparam int MAX_TAG       = 2048;
  localparam int POOL_SIZE     = 12;

  logic clk;
  logic rst;

  twctl_in_if  instr_ch ();
  twctl_out_if result_ch ();

  two_way_cache_tag_lookup u_dut (
    .clk    (clk),
    .rst    (rst),
    .instr  (instr_ch),
    .result (result_ch)
  );

  // Shadow copy of the tag store and its valid bits
  logic [TAG_W-1:0] shadow_tags  [NUM_SETS][NUM_WAYS];
  logic             shadow_valid [NUM_SETS][NUM_WAYS];

  lookup_result_t pending_lookups[$];
  int fail_count = 0;
  int burst_left = 1;

  // Receiver stall pattern state
  int stall_mode = 0;
  int stall_left = 0;
  int stall_tick = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Look up one instruction in the shadow store, fill on a miss, return the outcome
  function automatic lookup_result_t lookup_and_fill(input logic [INSTR_W-1:0] word);
    lookup_result_t res;
    logic [OPCODE_W-1:0] opcode;
    int waddr;
    int set_idx;
    logic [TAG_W-1:0] tag;
    logic [WAY_W-1:0] way;
    res = '0;
    opcode = word[OPCODE_LSB +: OPCODE_W];
    if (opcode != OP_LOAD && opcode != OP_STORE) begin
      res.status = ST_NOMEM;
      return res;
    end
    waddr = (int'(word[OFFSET_W-1:0]) + int'(word[RS_LSB +: RS_W])) / 4;
    set_idx = waddr % NUM_SETS;
    tag = TAG_W'(waddr / NUM_SETS);
    if (shadow_valid[set_idx][0] && shadow_tags[set_idx][0] == tag) begin
      res.status = ST_HIT;
      way = 1'b0;
    end else if (shadow_valid[set_idx][1] && shadow_tags[set_idx][1] == tag) begin
      res.status = ST_HIT;
      way = 1'b1;
    end else begin
      res.status = ST_MISS;
      way = shadow_valid[set_idx][0] ? 1'b1 : 1'b0;
    end
    shadow_tags[set_idx][way]  = tag;
    shadow_valid[set_idx][way] = 1'b1;
    res.set_num = SET_OUT_W'(set_idx);
    res.tag     = tag;
    res.way     = way;
    res.waddr   = WADDR_W'(waddr);
    return res;
  endfunction

  function automatic logic [INSTR_W-1:0] encode_instr(input logic [OPCODE_W-1:0] op,
                                                      input int rs, input int rt,
                                                      input int offset);
    return {op, 5'(rs), 5'(rt), 16'(offset)};
  endfunction

  // Split a byte address into rs plus offset at random, with random rt
  function automatic logic [INSTR_W-1:0] mem_word(input logic [OPCODE_W-1:0] op,
                                                  input int byte_addr);
    int rs_lo;
    int rs_hi;
    int rs;
    rs_lo = (byte_addr > 65535) ? byte_addr - 65535 : 0;
    rs_hi = (byte_addr < 31) ? byte_addr : 31;
    rs = $urandom_range(rs_hi, rs_lo);
    return encode_instr(op, rs, $urandom_range(31, 0), byte_addr - rs);
  endfunction

  function automatic int byte_of(input int tag, input int set_idx);
    int base;
    base = (tag * NUM_SETS + set_idx) * 4;
    return (base + 3 <= MAX_BYTE_ADDR) ? base + $urandom_range(3, 0) : base;
  endfunction

  function automatic logic [INSTR_W-1:0] non_mem_word();
    logic [OPCODE_W-1:0] op;
    logic [INSTR_W-1:0] word;
    do op = OPCODE_W'($urandom); while (op == OP_LOAD || op == OP_STORE);
    word = $urandom;
    word[OPCODE_LSB +: OPCODE_W] = op;
    return word;
  endfunction

  function automatic logic [OPCODE_W-1:0] any_mem_op();
    return $urandom_range(1, 0) ? OP_LOAD : OP_STORE;
  endfunction

  // Present one word, hold until the transfer, record its expected outcome, and idle between bursts
  task automatic send_instr(input logic [INSTR_W-1:0] word);
    instr_ch.valid <= 1'b1;
    instr_ch.instruction_word <= word;
    do @(posedge clk); while (!instr_ch.ready);
    pending_lookups.push_back(lookup_and_fill(word));
    burst_left--;
    if (burst_left <= 0) begin
      instr_ch.valid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk);
      burst_left = $urandom_range(40, 1);
    end
  endtask

  task automatic flag_field_mismatch(input string field, input int want, input int got);
    $error("%s: expected %0d, got %0d", field, want, got);
    fail_count++;
  endtask

  // Check each result transfer against the oldest expectation, then pick next ready
  always @(posedge clk) begin
    lookup_result_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (pending_lookups.size() == 0) begin
        $error("result transfer with no lookup outstanding");
        fail_count++;
      end else begin
        want = pending_lookups.pop_front();
        if (result_ch.access_status !== want.status)
          flag_field_mismatch("access_status", want.status, result_ch.access_status);
        if (result_ch.set_number !== want.set_num)
          flag_field_mismatch("set_number", want.set_num, result_ch.set_number);
        if (result_ch.tag_value !== want.tag)
          flag_field_mismatch("tag_value", want.tag, result_ch.tag_value);
        if (result_ch.way_used !== want.way)
          flag_field_mismatch("way_used", want.way, result_ch.way_used);
        if (result_ch.word_address !== want.waddr)
          flag_field_mismatch("word_address", want.waddr, result_ch.word_address);
      end
    end
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else begin
      if (stall_left <= 0) begin
        stall_mode = $urandom_range(3, 0);
        stall_left = $urandom_range(80, 16);
      end
      stall_left--;
      stall_tick++;
      case (stall_mode)
        0: result_ch.ready <= 1'b1;
        1: result_ch.ready <= 1'($urandom_range(1, 0));
        2: result_ch.ready <= (stall_tick % 4 == 0);
        default: result_ch.ready <= ($urandom_range(7, 0) == 0);
      endcase
    end
  end

  // Opcodes next to and far from load/store, with other bits all set or mostly clear, plus one random word
  task automatic test_non_memory_ops();
    send_instr(encode_instr(6'd0, 31, 31, 16'hFFFF));
    send_instr(encode_instr(6'd63, 31, 31, 16'hFFFF));
    send_instr(encode_instr(OP_LOAD - 6'd1, 5, 0, 16'h0040));
    send_instr(encode_instr(OP_STORE + 6'd1, 0, 0, 0));
    send_instr(non_mem_word());
  endtask

  // Address field extremes; the first access to tag zero must still miss
  task automatic test_field_extremes();
    send_instr(encode_instr(OP_LOAD, 0, 0, 0));
    send_instr(encode_instr(OP_STORE, 0, 31, 0));
    send_instr(encode_instr(OP_STORE, 31, 31, 16'hFFFF));
    send_instr(encode_instr(OP_LOAD, 31, 0, 16'hFFFF));
    send_instr(encode_instr(OP_LOAD, 0, 31, 16'hFFFF));
    send_instr(encode_instr(OP_STORE, 31, 0, 0));
  endtask

  // Fill both ways of one set, hit each, then force replacement of way 1
  task automatic test_hit_and_replacement();
    send_instr(mem_word(OP_LOAD, byte_of(10, 5)));
    send_instr(mem_word(OP_LOAD, byte_of(10, 5)));
    send_instr(mem_word(OP_STORE, byte_of(20, 5)));
    send_instr(mem_word(OP_LOAD, byte_of(20, 5)));
    send_instr(mem_word(OP_STORE, byte_of(10, 5)));
    send_instr(mem_word(OP_LOAD, byte_of(30, 5)));
    send_instr(mem_word(OP_LOAD, byte_of(10, 5)));
    send_instr(mem_word(OP_STORE, byte_of(20, 5)));
    send_instr(mem_word(OP_LOAD, byte_of(30, 5)));
  endtask

  // Mostly accesses from a small rotating working set, with stray addresses and non-memory ops
  task automatic test_random_traffic(input int count);
    int pool_tag [POOL_SIZE];
    int pool_set [POOL_SIZE];
    int pick;
    int focus_set;
    for (int i = 0; i < count; i++) begin
      if (i % 150 == 0) begin
        focus_set = $urandom_range(NUM_SETS - 1, 0);
        for (int j = 0; j < POOL_SIZE; j++) begin
          pool_tag[j] = ($urandom_range(9, 0) == 0) ? MAX_TAG : $urandom_range(MAX_TAG, 0);
          pool_set[j] = (j < 4) ? focus_set : $urandom_range(NUM_SETS - 1, 0);
        end
      end
      pick = $urandom_range(99, 0);
      if (pick < 12) begin
        send_instr(non_mem_word());
      end else if (pick < 20) begin
        send_instr(mem_word(any_mem_op(), $urandom_range(MAX_BYTE_ADDR, 0)));
      end else begin
        pick = $urandom_range(POOL_SIZE - 1, 0);
        send_instr(mem_word(any_mem_op(), byte_of(pool_tag[pick], pool_set[pick])));
      end
    end
  endtask

  initial begin
    rst <= 1'b1;
    instr_ch.valid <= 1'b0;
    instr_ch.instruction_word <= '0;
    for (int s = 0; s < NUM_SETS; s++) begin
      for (int w = 0; w < NUM_WAYS; w++) begin
        shadow_tags[s][w]  = '0;
        shadow_valid[s][w] = 1'b0;
      end
    end
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_non_memory_ops();
    test_field_extremes();
    test_hit_and_replacement();
    test_random_traffic(1630);

    // Drop valid, drain outstanding lookups, then allow the pipeline to settle
    instr_ch.valid <= 1'b0;
    while (pending_lookups.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Abort a hung run
  initial begin
    #5ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule
